/* src/fcm_pkg.sv */
// Shared types, constants and helpers for the frontier cell marker.
// No dependencies; imported by the output queue and the core.
package fcm_pkg;

    localparam int CELL_W         = 8;
    localparam int INDEX_W        = 20;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 2;
    localparam int SIZE_W         = 13;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int GRID_SIZE_RST  = 1024;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - INDEX_W - 1;
    localparam int OUT_TUSER_W = 1;

    localparam logic [CELL_W-1:0] FREE_VAL       = 8'd0;
    localparam logic [CELL_W-1:0] UNEXPLORED_VAL = 8'd50;
    localparam logic [CELL_W-1:0] BORDER_VAL     = 8'd100;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // result slots of one input word, in delivery order
    localparam int NUM_SLOTS = 3;
    localparam logic [1:0] SLOT_ABOVE = 2'd0;  // cell one row up, same column
    localparam logic [1:0] SLOT_LEFT  = 2'd1;  // last row, previous column
    localparam logic [1:0] SLOT_HERE  = 2'd2;  // last cell of the frame

    typedef struct packed {
        logic [NUM_SLOTS-1:0] present;
        logic [NUM_SLOTS-1:0] front;
        logic [INDEX_W-1:0]   idx_above;
        logic [INDEX_W-1:0]   idx_left;
        logic [INDEX_W-1:0]   idx_here;
    } t_result_set;

    function automatic logic frontier_test(
        input logic [CELL_W-1:0] mid,
        input logic [CELL_W-1:0] left,
        input logic [CELL_W-1:0] right,
        input logic [CELL_W-1:0] up,
        input logic [CELL_W-1:0] down
    );
        frontier_test = (mid == FREE_VAL) &&
                        (left == UNEXPLORED_VAL || right == UNEXPLORED_VAL ||
                         up == UNEXPLORED_VAL || down == UNEXPLORED_VAL);
    endfunction

    // zero acts as one, anything above the limit clips to it
    function automatic logic [SIZE_W-1:0] eff_size(
        input logic [CFG_DATA_W-1:0] value,
        input logic [SIZE_W-1:0]     max_size
    );
        logic [SIZE_W-1:0] wide;
        wide = SIZE_W'(value);
        if (wide == '0) begin
            eff_size = SIZE_W'(1);
        end else if (wide > max_size) begin
            eff_size = max_size;
        end else begin
            eff_size = wide;
        end
    endfunction

endpackage

/* src/fcm_line_mem.sv */
// One line store: synchronous RAM, one write port, one read port,
// registered read data. No dependencies.
module fcm_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/fcm_out_queue.sv */
// Output register stage: holds the up to three results of one input word
// and hands them out one per word. Depends on fcm_pkg.
module fcm_out_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load_valid,
    output logic                                o_load_ready,
    input  fcm_pkg::t_result_set                i_load,
    output logic                                o_tvalid,
    input  logic                                i_tready,
    output logic [fcm_pkg::OUT_TDATA_W-1:0]     o_tdata,
    output logic                                o_tlast,
    output logic [fcm_pkg::OUT_TUSER_W-1:0]     o_tuser
);
    import fcm_pkg::*;

    logic [NUM_SLOTS-1:0] r_mask;
    logic [NUM_SLOTS-1:0] r_front;
    logic [INDEX_W-1:0]   r_idx [NUM_SLOTS];

    logic [1:0]           sel;
    logic [NUM_SLOTS-1:0] n_mask;
    logic                 take;
    logic                 last;
    logic                 load;

    // lowest pending slot goes first
    always_comb begin
        sel = SLOT_HERE;
        if (r_mask[SLOT_ABOVE]) begin
            sel = SLOT_ABOVE;
        end else if (r_mask[SLOT_LEFT]) begin
            sel = SLOT_LEFT;
        end
        n_mask      = r_mask;
        n_mask[sel] = 1'b0;
    end

    assign last         = (n_mask == '0);
    assign take         = (r_mask != '0) && i_tready;
    assign o_load_ready = (r_mask == '0) || (take && last);
    assign load         = i_load_valid && o_load_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (load) begin
            r_mask <= i_load.present;
        end else if (take) begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_front                <= i_load.front;
            r_idx[SLOT_ABOVE]      <= i_load.idx_above;
            r_idx[SLOT_LEFT]       <= i_load.idx_left;
            r_idx[SLOT_HERE]       <= i_load.idx_here;
        end
    end

    assign o_tvalid   = (r_mask != '0);
    assign o_tdata    = {{OUT_PAD_W{1'b0}}, r_front[sel], r_idx[sel]};
    assign o_tlast    = last;
    assign o_tuser[0] = (sel == SLOT_HERE);

endmodule

/* src/frontier_cell_marker_core.sv */
// Path: the result for row r-1 is formed in the evaluate stage from the input word of
// row r, same column, and leaves through the output register stage; so do last-row results.
// Throughput: one input word per cycle unless a full output queue holds the evaluate stage;
// in the last row the single output port sets the pace (up to two results per word, three
// for the final cell). Reset: sizes 1024 (clipped to MAX_WIDTH/MAX_HEIGHT), position zero,
// pipeline empty. Line stores are not cleared and need no clearing pass.
module frontier_cell_marker_core #(
    parameter int MAX_WIDTH  = fcm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fcm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fcm_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [7:0] cell_value
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fcm_pkg::OUT_TDATA_W-1:0]    o_m_tdata,   // [19:0] cell_index,
                                                            // [20] is_frontier, [23:21] 0
    output logic                               o_m_tlast,   // run_end
    output logic [fcm_pkg::OUT_TUSER_W-1:0]    o_m_tuser,   // [0] frame_end
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fcm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [fcm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fcm_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);

    localparam logic [SIZE_W-1:0] MAX_W_S = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_S = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] RST_W_S = eff_size(CFG_DATA_W'(GRID_SIZE_RST), MAX_W_S);
    localparam logic [SIZE_W-1:0] RST_H_S = eff_size(CFG_DATA_W'(GRID_SIZE_RST), MAX_H_S);

    // ---------------------------------------------------------------
    // Size registers. Kept as effective width and last col/row so the
    // datapath never sees a zero or oversize value.
    // ---------------------------------------------------------------
    logic [WW-1:0]     r_eff_w;
    logic [AW-1:0]     r_last_col;
    logic [HW-1:0]     r_last_row;
    logic [SIZE_W-1:0] cfg_w_size;
    logic [SIZE_W-1:0] cfg_h_size;
    logic              cfg_restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_w_size  = eff_size(i_cfg_data, MAX_W_S);
    assign cfg_h_size  = eff_size(i_cfg_data, MAX_H_S);
    // a write to a known register restarts the frame; others are dropped
    assign cfg_restart = i_cfg_valid &&
                         (i_cfg_index == REG_GRID_WIDTH || i_cfg_index == REG_GRID_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_w    <= WW'(RST_W_S);
            r_last_col <= AW'(RST_W_S - SIZE_W'(1));
            r_last_row <= HW'(RST_H_S - SIZE_W'(1));
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GRID_WIDTH: begin
                    r_eff_w    <= WW'(cfg_w_size);
                    r_last_col <= AW'(cfg_w_size - SIZE_W'(1));
                end
                REG_GRID_HEIGHT: begin
                    r_last_row <= HW'(cfg_h_size - SIZE_W'(1));
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Accept side: raster position of the next input word and the
    // line store read addresses for it.
    // ---------------------------------------------------------------
    logic               s_accept;
    logic [AW-1:0]      r_col;
    logic [HW-1:0]      r_row;
    logic [INDEX_W-1:0] r_idx;
    logic               in_col_last;
    logic               in_row_last;
    logic [AW-1:0]      pend_rd_addr;
    logic [AW-1:0]      upper_rd_addr;

    assign s_accept    = i_s_tvalid && o_s_tready;
    assign in_col_last = (r_col == r_last_col);
    assign in_row_last = (r_row == r_last_row);

    // Pending row is read one column ahead: that value is this word's
    // right neighbor and the next word's center. The last column instead
    // prefetches column 0 for the start of the next row.
    assign pend_rd_addr  = in_col_last ? '0 : r_col + AW'(1);
    assign upper_rd_addr = r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (s_accept) begin
            if (in_col_last) begin
                r_col <= '0;
                r_row <= in_row_last ? '0 : r_row + HW'(1);
            end else begin
                r_col <= r_col + AW'(1);
            end
            r_idx <= (in_col_last && in_row_last) ? '0 : r_idx + INDEX_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Evaluate stage: read data is back, results are formed, and the
    // line stores are written as the word leaves.
    // ---------------------------------------------------------------
    logic               r_b_valid;
    logic [CELL_W-1:0]  r_b_cell;
    logic [AW-1:0]      r_b_col;
    logic [INDEX_W-1:0] r_b_idx;
    logic               r_b_col_gt0;
    logic               r_b_col_last;
    logic               r_b_row_gt0;
    logic               r_b_row_gt1;
    logic               r_b_row_last;
    logic               r_b_fwd_p;
    logic [CELL_W-1:0]  r_b_fwd_p_data;
    logic               r_b_fwd_u;
    logic [CELL_W-1:0]  r_b_fwd_u_data;

    // row history, advanced as each word leaves the stage
    logic [CELL_W-1:0]  r_mid;        // row r-1 at this column
    logic [CELL_W-1:0]  r_prev_mid;   // row r-1 at the previous column
    logic [CELL_W-1:0]  r_prev_cell;  // current row, previous column
    logic [CELL_W-1:0]  r_prev_left;  // current row, two columns back

    logic [CELL_W-1:0]  pend_q;
    logic [CELL_W-1:0]  upper_q;
    logic [CELL_W-1:0]  pend_rd;
    logic [CELL_W-1:0]  up_rd;
    logic [CELL_W-1:0]  n_mid;
    logic               b_adv;
    logic               q_load_ready;
    t_result_set        b_set;

    // Write-through for a word that reads the entry the leaving word
    // writes in the same cycle (narrow grids only).
    assign pend_rd = r_b_fwd_p ? r_b_fwd_p_data : pend_q;
    assign up_rd   = r_b_fwd_u ? r_b_fwd_u_data : upper_q;

    // single-column grid: next row's center is this very word
    assign n_mid = (r_b_col_last && !r_b_col_gt0) ? r_b_cell : pend_rd;

    always_comb begin
        logic [CELL_W-1:0] left_a;
        logic [CELL_W-1:0] right_a;
        logic [CELL_W-1:0] up_a;
        logic [CELL_W-1:0] up_l;
        logic [CELL_W-1:0] up_h;
        left_a  = r_b_col_gt0  ? r_prev_mid : BORDER_VAL;
        right_a = r_b_col_last ? BORDER_VAL : pend_rd;
        up_a    = r_b_row_gt1  ? up_rd      : BORDER_VAL;
        up_l    = r_b_row_gt0  ? r_prev_mid : BORDER_VAL;
        up_h    = r_b_row_gt0  ? r_mid      : BORDER_VAL;

        b_set                     = '0;
        b_set.present[SLOT_ABOVE] = r_b_row_gt0;
        b_set.present[SLOT_LEFT]  = r_b_row_last && r_b_col_gt0;
        b_set.present[SLOT_HERE]  = r_b_row_last && r_b_col_last;
        b_set.front[SLOT_ABOVE]   = frontier_test(r_mid, left_a, right_a, up_a, r_b_cell);
        b_set.front[SLOT_LEFT]    = frontier_test(r_prev_cell, r_prev_left, r_b_cell,
                                                  up_l, BORDER_VAL);
        b_set.front[SLOT_HERE]    = frontier_test(r_b_cell, r_prev_cell, BORDER_VAL,
                                                  up_h, BORDER_VAL);
        b_set.idx_above           = r_b_idx - INDEX_W'(r_eff_w);
        b_set.idx_left            = r_b_idx - INDEX_W'(1);
        b_set.idx_here            = r_b_idx;
    end

    // a word with no results leaves without waiting on the queue
    assign b_adv      = r_b_valid && ((b_set.present == '0) || q_load_ready);
    assign o_s_tready = !r_b_valid || b_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (s_accept) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_b_cell       <= i_s_tdata[CELL_W-1:0];
            r_b_col        <= r_col;
            r_b_idx        <= r_idx;
            r_b_col_gt0    <= (r_col != '0);
            r_b_col_last   <= in_col_last;
            r_b_row_gt0    <= (r_row != '0);
            r_b_row_gt1    <= (r_row > HW'(1));
            r_b_row_last   <= in_row_last;
            r_b_fwd_p      <= b_adv && (pend_rd_addr == r_b_col);
            r_b_fwd_p_data <= r_b_cell;
            r_b_fwd_u      <= b_adv && r_b_row_gt0 && (upper_rd_addr == r_b_col);
            r_b_fwd_u_data <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_mid      <= n_mid;
            r_prev_mid <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_prev_cell <= BORDER_VAL;
            r_prev_left <= BORDER_VAL;
        end else if (b_adv) begin
            if (r_b_col_last) begin
                r_prev_cell <= BORDER_VAL;
                r_prev_left <= BORDER_VAL;
            end else begin
                r_prev_cell <= r_b_cell;
                r_prev_left <= r_prev_cell;
            end
        end
    end

    // pending row: row above the input; upper row: two rows above
    fcm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_pend_mem (
        .i_clk     (i_clk),
        .i_wr_en   (b_adv),
        .i_wr_addr (r_b_col),
        .i_wr_data (r_b_cell),
        .i_rd_en   (s_accept),
        .i_rd_addr (pend_rd_addr),
        .o_rd_data (pend_q)
    );

    fcm_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_upper_mem (
        .i_clk     (i_clk),
        .i_wr_en   (b_adv && r_b_row_gt0),
        .i_wr_addr (r_b_col),
        .i_wr_data (r_mid),
        .i_rd_en   (s_accept),
        .i_rd_addr (upper_rd_addr),
        .o_rd_data (upper_q)
    );

    // ---------------------------------------------------------------
    // Output register stage
    // ---------------------------------------------------------------
    fcm_out_queue u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_b_valid && (b_set.present != '0)),
        .o_load_ready (q_load_ready),
        .i_load       (b_set),
        .o_tvalid     (o_m_tvalid),
        .i_tready     (i_m_tready),
        .o_tdata      (o_m_tdata),
        .o_tlast      (o_m_tlast),
        .o_tuser      (o_m_tuser)
    );

`ifndef SYNTH
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= r_last_col) && (r_row <= r_last_row))
        else $error("raster position beyond grid size");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_b_valid)
        else $error("accepted word lost before evaluate stage");

    a_upper_fwd_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_fwd_u) |-> (r_last_col == '0))
        else $error("upper row bypass on a grid wider than one column");

    a_pend_fwd_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_fwd_p) |-> (r_last_col <= AW'(1)))
        else $error("pending row bypass on a grid wider than two columns");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> o_m_tlast)
        else $error("frame end not on last result of its word");
`endif

endmodule

/* tb/frontier_cell_marker_core_test.sv */
// Self-checking regression for frontier_cell_marker_core: streams map cells, predicts every
// frontier result with a scoreboard class and checks the result stream word by word.
// Depends on fcm_pkg (constants, register indexes) and the core RTL only.

typedef struct {
    logic [fcm_pkg::INDEX_W-1:0] cell_index;
    logic                        is_frontier;
    logic                        run_end;
    logic                        frame_end;
} t_cell_mark;

// Scoreboard: own copy of the line stores and raster position, queue of expected marks.
class frontier_predictor;
    logic [fcm_pkg::CFG_DATA_W-1:0] width_reg;
    logic [fcm_pkg::CFG_DATA_W-1:0] height_reg;
    logic [fcm_pkg::CELL_W-1:0]     upper_row [fcm_pkg::DEF_MAX_WIDTH];
    logic [fcm_pkg::CELL_W-1:0]     pending_row [fcm_pkg::DEF_MAX_WIDTH];
    int unsigned                    col;
    int unsigned                    row;
    logic [fcm_pkg::CELL_W-1:0]     last_cell;
    logic [fcm_pkg::CELL_W-1:0]     last_left_cell;
    t_cell_mark                     expected_marks[$];
    int                             errors;

    function new();
        width_reg  = fcm_pkg::CFG_DATA_W'(fcm_pkg::GRID_SIZE_RST);
        height_reg = fcm_pkg::CFG_DATA_W'(fcm_pkg::GRID_SIZE_RST);
        errors     = 0;
        restart();
    endfunction

    function void restart();
        col            = 0;
        row            = 0;
        last_cell      = fcm_pkg::BORDER_VAL;
        last_left_cell = fcm_pkg::BORDER_VAL;
    endfunction

    function int unsigned clip(logic [fcm_pkg::CFG_DATA_W-1:0] value, int unsigned max_size);
        if (value == 0) return 1;
        if (int'(value) > max_size) return max_size;
        return value;
    endfunction

    function logic frontier(logic [7:0] mid, logic [7:0] l, logic [7:0] r,
                            logic [7:0] u, logic [7:0] d);
        if (mid != fcm_pkg::FREE_VAL) return 1'b0;
        return (l == fcm_pkg::UNEXPLORED_VAL) || (r == fcm_pkg::UNEXPLORED_VAL) ||
               (u == fcm_pkg::UNEXPLORED_VAL) || (d == fcm_pkg::UNEXPLORED_VAL);
    endfunction

    function t_cell_mark make_mark(int unsigned r, int unsigned c, int unsigned w, logic front);
        t_cell_mark m;
        m.cell_index  = fcm_pkg::INDEX_W'(r * w + c);
        m.is_frontier = front;
        m.run_end     = 1'b0;
        m.frame_end   = 1'b0;
        return m;
    endfunction

    function void write_reg(logic [fcm_pkg::CFG_INDEX_W-1:0] index,
                            logic [fcm_pkg::CFG_DATA_W-1:0] value);
        case (index)
            fcm_pkg::REG_GRID_WIDTH: begin
                width_reg = value;
                restart();
            end
            fcm_pkg::REG_GRID_HEIGHT: begin
                height_reg = value;
                restart();
            end
            default: begin
            end
        endcase
    endfunction

    function void note_cell(logic [fcm_pkg::CELL_W-1:0] v);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        logic [7:0]  mid;
        logic [7:0]  lf;
        logic [7:0]  rt;
        logic [7:0]  up;
        t_cell_mark  batch[3];
        int          n;
        w = clip(width_reg, fcm_pkg::DEF_MAX_WIDTH);
        h = clip(height_reg, fcm_pkg::DEF_MAX_HEIGHT);
        c = col;
        r = row;
        n = 0;
        if (c >= w || r >= h) begin
            c = 0;
            r = 0;
        end
        // cell one row up is complete now that its lower neighbour is here
        if (r > 0) begin
            mid = pending_row[c];
            lf  = (c > 0) ? upper_row[c-1] : fcm_pkg::BORDER_VAL;
            rt  = (c + 1 < w) ? pending_row[c+1] : fcm_pkg::BORDER_VAL;
            up  = (r > 1) ? upper_row[c] : fcm_pkg::BORDER_VAL;
            batch[n] = make_mark(r - 1, c, w, frontier(mid, lf, rt, up, v));
            n++;
            upper_row[c] = mid;
        end
        pending_row[c] = v;
        // bottom row: left neighbour's right side just arrived, last cell closes the frame
        if (r == h - 1) begin
            if (c > 0) begin
                lf = (c > 1) ? last_left_cell : fcm_pkg::BORDER_VAL;
                up = (r > 0) ? upper_row[c-1] : fcm_pkg::BORDER_VAL;
                batch[n] = make_mark(r, c - 1, w,
                    frontier(last_cell, lf, v, up, fcm_pkg::BORDER_VAL));
                n++;
            end
            if (c == w - 1) begin
                lf = (c > 0) ? last_cell : fcm_pkg::BORDER_VAL;
                up = (r > 0) ? upper_row[c] : fcm_pkg::BORDER_VAL;
                batch[n] = make_mark(r, c, w,
                    frontier(v, lf, fcm_pkg::BORDER_VAL, up, fcm_pkg::BORDER_VAL));
                batch[n].frame_end = 1'b1;
                n++;
            end
        end
        if (n > 0) batch[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++) expected_marks = {expected_marks, batch[k]};

        last_left_cell = last_cell;
        last_cell      = v;
        if (c + 1 < w) begin
            col = c + 1;
            row = r;
        end else begin
            col            = 0;
            last_cell      = fcm_pkg::BORDER_VAL;
            last_left_cell = fcm_pkg::BORDER_VAL;
            row            = (r + 1 < h) ? r + 1 : 0;
        end
    endfunction

    function void check_mark(logic [fcm_pkg::OUT_TDATA_W-1:0] tdata, logic tlast, logic tuser);
        t_cell_mark m;
        if (expected_marks.size() == 0) begin
            $error("unexpected result word: cell_index %0d", tdata[fcm_pkg::INDEX_W-1:0]);
            errors++;
            return;
        end
        m = expected_marks.pop_front();
        if (tdata[fcm_pkg::INDEX_W-1:0] != m.cell_index) begin
            $error("cell_index: expected %0d, actual %0d",
                   m.cell_index, tdata[fcm_pkg::INDEX_W-1:0]);
            errors++;
        end
        if (tdata[fcm_pkg::INDEX_W] != m.is_frontier) begin
            $error("is_frontier: expected %0b, actual %0b", m.is_frontier,
                   tdata[fcm_pkg::INDEX_W]);
            errors++;
        end
        if (tdata[fcm_pkg::OUT_TDATA_W-1:fcm_pkg::INDEX_W+1] != 0) begin
            $error("pad: expected 0, actual %0d", tdata[fcm_pkg::OUT_TDATA_W-1:fcm_pkg::INDEX_W+1]);
            errors++;
        end
        if (tlast != m.run_end) begin
            $error("run_end: expected %0b, actual %0b", m.run_end, tlast);
            errors++;
        end
        if (tuser != m.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", m.frame_end, tuser);
            errors++;
        end
    endfunction

    function int outstanding();
        return expected_marks.size();
    endfunction
endclass

module frontier_cell_marker_core_test;

    // generous bound; the slowest correct run stays well below it
    localparam int CYCLE_LIMIT = 400000;
    // indexes past the two size registers; writes there must change nothing
    localparam logic [fcm_pkg::CFG_INDEX_W-1:0] REG_UNUSED     = 2'd2;
    localparam logic [fcm_pkg::CFG_INDEX_W-1:0] REG_UNUSED_TOP = 2'd3;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [fcm_pkg::IN_TDATA_W-1:0] i_s_tdata   = '0;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic [fcm_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                           o_m_tlast;
    logic [fcm_pkg::OUT_TUSER_W-1:0] o_m_tuser;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [fcm_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [fcm_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    frontier_predictor predictor = new();

    int send_idle_pct  = 0;   // chance per cycle that the cell source holds off
    int recv_stall_pct = 0;   // chance per cycle that the result sink stalls
    int cycle_count    = 0;

    frontier_cell_marker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("frontier_cell_marker_core regression: fail");
            $finish;
        end
    end

    // result sink: ready changes on the falling edge only
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // every accepted result word goes against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            predictor.check_mark(o_m_tdata, o_m_tlast, o_m_tuser[0]);
        end
    end

    // Starts and ends on a falling edge; valid stays high between back-to-back words,
    // so it gets a single assignment per time step.
    task automatic send_cell(input logic [fcm_pkg::CELL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        predictor.note_cell(value);
        @(negedge i_clk);
    endtask

    task automatic stop_stream();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Idle point for register writes: all results in, then a further wait for row-zero
    // words, which leave no result behind but may still be in flight.
    task automatic wait_marks_drained();
        while (predictor.outstanding() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_grid_reg(input logic [fcm_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [fcm_pkg::CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        predictor.write_reg(index, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly free and unexplored cells so that frontiers actually occur
    function automatic logic [fcm_pkg::CELL_W-1:0] random_cell();
        case ($urandom_range(9))
            0, 1, 2, 3: return fcm_pkg::FREE_VAL;
            4, 5, 6:    return fcm_pkg::UNEXPLORED_VAL;
            7:          return fcm_pkg::BORDER_VAL;
            default:    return fcm_pkg::CELL_W'($urandom_range(255));
        endcase
    endfunction

    // One grid setting: program the sizes, stream random cells across frame wraps,
    // optionally hold the source off once until the result queue is empty.
    task automatic run_grid(input logic [fcm_pkg::CFG_DATA_W-1:0] w_value,
                            input logic [fcm_pkg::CFG_DATA_W-1:0] h_value,
                            input int cells, input bit hold_off);
        int hold_at;
        hold_at = hold_off ? $urandom_range(cells - 1) : -1;
        wait_marks_drained();
        write_grid_reg(fcm_pkg::REG_GRID_WIDTH, w_value);
        write_grid_reg(fcm_pkg::REG_GRID_HEIGHT, h_value);
        if ($urandom_range(3) == 0) begin
            write_grid_reg(REG_UNUSED_TOP, fcm_pkg::CFG_DATA_W'($urandom_range(2047)));
        end
        for (int k = 0; k < cells; k++) begin
            if (k == hold_at) begin
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
                while (predictor.outstanding() != 0) @(negedge i_clk);
            end
            send_cell(random_cell());
        end
        stop_stream();
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        // reset sizes: two row-zero words, no results, extreme byte values
        send_cell(8'h7F);
        send_cell(8'h80);
        stop_stream();
        wait_marks_drained();

        // 3x3 grid: frontiers from right, left, up, down and horizontal neighbours,
        // an occupied cell and a negative cell that is neither free nor unexplored
        write_grid_reg(fcm_pkg::REG_GRID_WIDTH, 11'd3);
        write_grid_reg(fcm_pkg::REG_GRID_HEIGHT, 11'd3);
        send_cell(fcm_pkg::FREE_VAL);
        send_cell(fcm_pkg::UNEXPLORED_VAL);
        send_cell(fcm_pkg::FREE_VAL);
        send_cell(fcm_pkg::BORDER_VAL);
        send_cell(fcm_pkg::FREE_VAL);
        send_cell(fcm_pkg::FREE_VAL);
        send_cell(8'h80);
        send_cell(fcm_pkg::FREE_VAL);
        send_cell(fcm_pkg::UNEXPLORED_VAL);
        stop_stream();
        wait_marks_drained();

        // 2x2 grid with a write to an unused index in mid-frame: position must hold
        write_grid_reg(fcm_pkg::REG_GRID_WIDTH, 11'd2);
        write_grid_reg(fcm_pkg::REG_GRID_HEIGHT, 11'd2);
        send_cell(fcm_pkg::FREE_VAL);
        stop_stream();
        wait_marks_drained();
        write_grid_reg(REG_UNUSED, 11'd5);
        send_cell(fcm_pkg::UNEXPLORED_VAL);
        send_cell(fcm_pkg::UNEXPLORED_VAL);
        send_cell(fcm_pkg::FREE_VAL);
        stop_stream();
        wait_marks_drained();

        // zero sizes act as one: every word is a whole 1x1 frame
        write_grid_reg(fcm_pkg::REG_GRID_WIDTH, 11'd0);
        write_grid_reg(fcm_pkg::REG_GRID_HEIGHT, 11'd0);
        send_cell(fcm_pkg::FREE_VAL);
        send_cell(fcm_pkg::UNEXPLORED_VAL);
        send_cell(8'h80);
        stop_stream();

        // --- random, four idling phases ---
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            repeat (2) begin
                run_grid(fcm_pkg::CFG_DATA_W'($urandom_range(12)),
                         fcm_pkg::CFG_DATA_W'($urandom_range(6)), 40, 1'b1);
            end
            if (phase == 0) begin
                // size extremes: saturated width in a single row, saturated height
                // in a single column
                run_grid(11'd2047, 11'd1, 40, 1'b0);
                run_grid(11'd1, 11'd2047, 40, 1'b0);
            end
        end

        // drain, then a little longer in case of stray words
        while (predictor.outstanding() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (predictor.errors == 0) begin
            $display("frontier_cell_marker_core regression: pass");
        end else begin
            $display("frontier_cell_marker_core regression: fail");
        end
        $finish;
    end

endmodule
